// ----- src/hvi_pkg.sv -----
// Shared constants and types for the HSV value inverter.
`default_nettype none

package hvi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CH_W          = 8;
  localparam int SUM_W         = 10;
  localparam int SPREAD_MAX    = 25;
  localparam int FULL_SUM      = 765;
  // reciprocal of FULL_SUM as a fixed-point multiplier, exact for products below 2^20
  localparam int RECIP_SH      = 30;

  localparam logic [SUM_W-1:0] SUPPRESS_RESET = SUM_W'(153);

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } maxsel_t;

  typedef enum logic [2:0] {
    SEXT_RED_YEL,
    SEXT_YEL_GRN,
    SEXT_GRN_CYN,
    SEXT_CYN_BLU,
    SEXT_BLU_MAG,
    SEXT_MAG_RED
  } sextant_t;

endpackage

`default_nettype wire

// ----- src/hvi_div.sv -----
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den) for num <= den.
`default_nettype none

module hvi_div #(
  parameter int FRAC_BITS = hvi_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [hvi_pkg::CH_W-1:0]   num_i,
  input  logic [hvi_pkg::CH_W-1:0]   den_i,
  output logic [FRAC_BITS:0]         quo_o
);
  import hvi_pkg::*;

  localparam int QW = FRAC_BITS + 1;

  logic [CH_W-1:0] rem_r [FRAC_BITS];
  logic [CH_W-1:0] den_r [FRAC_BITS];
  logic [QW-1:0]   quo_r [QW];

  // one quotient bit per stage, MSB (weight 2^FRAC_BITS) first
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [CH_W:0]   tw;
    logic [CH_W-1:0] den_src;
    logic [QW-1:0]   quo_src;
    logic            take;
    logic [CH_W-1:0] rem_nxt;
    logic [QW-1:0]   quo_nxt;

    if (k == 0) begin : g_first
      assign tw      = {1'b0, num_i};
      assign den_src = den_i;
      assign quo_src = '0;
    end else begin : g_next
      assign tw      = {rem_r[k-1], 1'b0};
      assign den_src = den_r[k-1];
      assign quo_src = quo_r[k-1];
    end

    always_comb begin
      take    = (tw >= {1'b0, den_src});
      rem_nxt = take ? CH_W'(tw - {1'b0, den_src}) : tw[CH_W-1:0];
      quo_nxt = quo_src;
      quo_nxt[FRAC_BITS-k] = take;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= quo_nxt;
      end
    end

    if (k < FRAC_BITS) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          den_r[k] <= den_src;
        end
      end
    end
  end

  assign quo_o = quo_r[FRAC_BITS];

endmodule

`default_nettype wire

// ----- src/hsv_value_inverter.sv -----
// Top level: RGB pixel to value-inverted RGB pixel, fully pipelined.
//
//   channel | direction | payload                               | handshake
//   --------+-----------+---------------------------------------+--------------------
//   in      | sink      | in_red_in, in_green_in, in_blue_in    | in_valid/in_ready
//   out     | source    | out_red_out, out_green_out, out_blue_out | out_valid/out_ready
//   cfg     | sink      | cfg_data (suppress sum, 10 bits)      | cfg_valid/cfg_ready
//
// One pixel is accepted per cycle while the output is not held; the pipeline runs through the two
// restoring dividers (saturation and hue fraction) that resolve one quotient bit
// per stage. Synchronous active-low reset clears the stage valid bits and sets the
// suppress sum to 153. A held output word freezes the whole pipeline; in_ready
// drops in that cycle and nothing is lost or repeated.
`default_nettype none

module hsv_value_inverter #(
  parameter int FRAC_BITS = hvi_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hvi_pkg::CH_W-1:0]    in_red_in,
  input  logic [hvi_pkg::CH_W-1:0]    in_green_in,
  input  logic [hvi_pkg::CH_W-1:0]    in_blue_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hvi_pkg::CH_W-1:0]    out_red_out,
  output logic [hvi_pkg::CH_W-1:0]    out_green_out,
  output logic [hvi_pkg::CH_W-1:0]    out_blue_out,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hvi_pkg::SUM_W-1:0]   cfg_data
);
  import hvi_pkg::*;

  localparam int QW    = FRAC_BITS + 1;
  localparam int NSTG  = FRAC_BITS + 7;
  localparam int DIV_A = (2 ** FRAC_BITS) / FULL_SUM;
  localparam int DIV_B = (2 ** FRAC_BITS) % FULL_SUM;
  localparam int AW    = $clog2(DIV_A + 1);
  localparam int YW    = 20;
  localparam int MW    = 21;
  localparam int RECIP_M = (2 ** RECIP_SH + FULL_SUM - 1) / FULL_SUM;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  logic                 adv;
  logic [NSTG-1:0]      vld_r;
  logic [SUM_W-1:0]     suppress_r;

  assign adv       = !vld_r[NSTG-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NSTG-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      suppress_r <= SUPPRESS_RESET;
    end else begin
      if (adv) begin
        vld_r <= {vld_r[NSTG-2:0], in_valid};
      end
      if (cfg_valid) begin
        suppress_r <= cfg_data;
      end
    end
  end

  // ---------------- stage 1: max, min, spread, sum ----------------
  maxsel_t          s1_sel_nxt, s1_sel_r;
  logic [CH_W-1:0]  s1_mx_nxt, s1_mn_nxt, s1_mx_r, s1_delta_r;
  logic [SUM_W-1:0] s1_sum_nxt, s1_sum_r;
  logic signed [CH_W:0] s1_diff_nxt, s1_diff_r;
  logic             s1_grey_r;

  always_comb begin
    if (in_red_in >= in_green_in && in_red_in >= in_blue_in) begin
      s1_sel_nxt  = MAX_RED;
      s1_mx_nxt   = in_red_in;
      s1_diff_nxt = $signed({1'b0, in_green_in}) - $signed({1'b0, in_blue_in});
    end else if (in_green_in >= in_blue_in) begin
      s1_sel_nxt  = MAX_GREEN;
      s1_mx_nxt   = in_green_in;
      s1_diff_nxt = $signed({1'b0, in_blue_in}) - $signed({1'b0, in_red_in});
    end else begin
      s1_sel_nxt  = MAX_BLUE;
      s1_mx_nxt   = in_blue_in;
      s1_diff_nxt = $signed({1'b0, in_red_in}) - $signed({1'b0, in_green_in});
    end
    s1_mn_nxt = in_red_in;
    if (in_green_in < s1_mn_nxt) s1_mn_nxt = in_green_in;
    if (in_blue_in < s1_mn_nxt)  s1_mn_nxt = in_blue_in;
    s1_sum_nxt = SUM_W'(in_red_in) + SUM_W'(in_green_in) + SUM_W'(in_blue_in);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sel_r   <= s1_sel_nxt;
      s1_mx_r    <= s1_mx_nxt;
      s1_delta_r <= s1_mx_nxt - s1_mn_nxt;
      s1_sum_r   <= s1_sum_nxt;
      s1_diff_r  <= s1_diff_nxt;
      s1_grey_r  <= ((s1_mx_nxt - s1_mn_nxt) <= CH_W'(SPREAD_MAX)) ||
                    (s1_sum_nxt < suppress_r);
    end
  end

  // ---------------- stage 2: hue numerator, value partial products ----------------
  logic [10:0]          s2_d2, s2_d4, s2_d6, s2_base;
  logic signed [11:0]   s2_num;
  logic [10:0]          s2_un_r;
  logic [SUM_W+AW-1:0]  s2_pa;
  logic [QW-1:0]        s2_pa_r;
  logic [YW-1:0]        s2_y_r;
  logic [CH_W-1:0]      s2_mx_r, s2_delta_r;
  logic                 s2_grey_r;

  always_comb begin
    s2_d2 = {2'b00, s1_delta_r, 1'b0};
    s2_d4 = {1'b0, s1_delta_r, 2'b00};
    s2_d6 = s2_d2 + s2_d4;
    case (s1_sel_r)
      MAX_GREEN: s2_base = s2_d2;
      MAX_BLUE:  s2_base = s2_d4;
      default:   s2_base = '0;
    endcase
    s2_num = $signed({1'b0, s2_base}) + $signed({{3{s1_diff_r[CH_W]}}, s1_diff_r});
    // wrap a negative hue into the full circle
    if (s2_num[11]) s2_num = s2_num + $signed({1'b0, s2_d6});
    s2_pa = (SUM_W+AW)'(s1_sum_r) * (SUM_W+AW)'(DIV_A);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_un_r    <= s2_num[10:0];
      s2_pa_r    <= QW'(s2_pa);
      s2_y_r     <= YW'(s1_sum_r) * YW'(DIV_B);
      s2_mx_r    <= s1_mx_r;
      s2_delta_r <= s1_delta_r;
      s2_grey_r  <= s1_grey_r;
    end
  end

  // ---------------- stage 3: sextant and remainder, value quotient ----------------
  logic [10:0]         s3_m1, s3_m2, s3_m3, s3_m4, s3_m5, s3_msel;
  sextant_t            s3_sext_nxt, s3_sext_r;
  logic [YW+MW-1:0]    s3_yprod;
  logic [CH_W-1:0]     s3_rem_r, s3_mx_r, s3_delta_r;
  logic [QW-1:0]       s3_pa_r;
  logic [SUM_W-1:0]    s3_yq_r;
  logic                s3_grey_r;

  always_comb begin
    s3_m1 = {3'b000, s2_delta_r};
    s3_m2 = {2'b00, s2_delta_r, 1'b0};
    s3_m4 = {1'b0, s2_delta_r, 2'b00};
    s3_m3 = s3_m1 + s3_m2;
    s3_m5 = s3_m1 + s3_m4;
    if (s2_un_r >= s3_m5) begin
      s3_sext_nxt = SEXT_MAG_RED;
      s3_msel     = s3_m5;
    end else if (s2_un_r >= s3_m4) begin
      s3_sext_nxt = SEXT_BLU_MAG;
      s3_msel     = s3_m4;
    end else if (s2_un_r >= s3_m3) begin
      s3_sext_nxt = SEXT_CYN_BLU;
      s3_msel     = s3_m3;
    end else if (s2_un_r >= s3_m2) begin
      s3_sext_nxt = SEXT_GRN_CYN;
      s3_msel     = s3_m2;
    end else if (s2_un_r >= s3_m1) begin
      s3_sext_nxt = SEXT_YEL_GRN;
      s3_msel     = s3_m1;
    end else begin
      s3_sext_nxt = SEXT_RED_YEL;
      s3_msel     = '0;
    end
    s3_yprod = (YW+MW)'(s2_y_r) * (YW+MW)'(RECIP_M);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sext_r  <= s3_sext_nxt;
      s3_rem_r   <= CH_W'(s2_un_r - s3_msel);
      s3_mx_r    <= s2_mx_r;
      s3_delta_r <= s2_delta_r;
      s3_pa_r    <= s2_pa_r;
      s3_yq_r    <= s3_yprod[RECIP_SH +: SUM_W];
      s3_grey_r  <= s2_grey_r;
    end
  end

  // ---------------- dividers: saturation and hue fraction ----------------
  logic [QW-1:0] sat_q, frac_q;

  hvi_div #(.FRAC_BITS(FRAC_BITS)) u_div_sat (
    .clk   (clk),
    .en    (adv),
    .num_i (s3_delta_r),
    .den_i (s3_mx_r),
    .quo_o (sat_q)
  );

  hvi_div #(.FRAC_BITS(FRAC_BITS)) u_div_frac (
    .clk   (clk),
    .en    (adv),
    .num_i (s3_rem_r),
    .den_i (s3_delta_r),
    .quo_o (frac_q)
  );

  // ---------------- stage 4: inverted value, then delay to meet the dividers ----------
  logic [QW-1:0] s4_vi_r;
  sextant_t      s4_sext_r;
  logic          s4_grey_r;
  logic [QW-1:0] dl_vi_r   [FRAC_BITS];
  sextant_t      dl_sext_r [FRAC_BITS];
  logic          dl_grey_r [FRAC_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_vi_r   <= ONE_Q - (s3_pa_r + QW'(s3_yq_r));
      s4_sext_r <= s3_sext_r;
      s4_grey_r <= s3_grey_r;
      dl_vi_r[0]   <= s4_vi_r;
      dl_sext_r[0] <= s4_sext_r;
      dl_grey_r[0] <= s4_grey_r;
      for (int i = 1; i < FRAC_BITS; i++) begin
        dl_vi_r[i]   <= dl_vi_r[i-1];
        dl_sext_r[i] <= dl_sext_r[i-1];
        dl_grey_r[i] <= dl_grey_r[i-1];
      end
    end
  end

  // ---------------- stage 5: s*frac and s*(1-frac) ----------------
  logic [2*QW-1:0] s5_sf_prod, s5_sg_prod;
  logic [QW-1:0]   s5_sf_r, s5_sg_r, s5_oms_r, s5_vi_r;
  sextant_t        s5_sext_r;
  logic            s5_grey_r;

  always_comb begin
    s5_sf_prod = (2*QW)'(sat_q) * (2*QW)'(frac_q);
    s5_sg_prod = (2*QW)'(sat_q) * (2*QW)'(ONE_Q - frac_q);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sf_r   <= s5_sf_prod[FRAC_BITS +: QW];
      s5_sg_r   <= s5_sg_prod[FRAC_BITS +: QW];
      s5_oms_r  <= ONE_Q - sat_q;
      s5_vi_r   <= dl_vi_r[FRAC_BITS-1];
      s5_sext_r <= dl_sext_r[FRAC_BITS-1];
      s5_grey_r <= dl_grey_r[FRAC_BITS-1];
    end
  end

  // ---------------- stage 6: p, q, t ----------------
  logic [2*QW-1:0] s6_p_prod, s6_q_prod, s6_t_prod;
  logic [QW-1:0]   s6_p_r, s6_q_r, s6_t_r, s6_vi_r;
  sextant_t        s6_sext_r;
  logic            s6_grey_r;

  always_comb begin
    s6_p_prod = (2*QW)'(s5_vi_r) * (2*QW)'(s5_oms_r);
    s6_q_prod = (2*QW)'(s5_vi_r) * (2*QW)'(ONE_Q - s5_sf_r);
    s6_t_prod = (2*QW)'(s5_vi_r) * (2*QW)'(ONE_Q - s5_sg_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_p_r    <= s6_p_prod[FRAC_BITS +: QW];
      s6_q_r    <= s6_q_prod[FRAC_BITS +: QW];
      s6_t_r    <= s6_t_prod[FRAC_BITS +: QW];
      s6_vi_r   <= s5_vi_r;
      s6_sext_r <= s5_sext_r;
      s6_grey_r <= s5_grey_r;
    end
  end

  // ---------------- stage 7: sextant select and scale to bytes ----------------
  logic [QW-1:0]   s7_r, s7_g, s7_b;
  logic [QW+7:0]   s7_rs, s7_gs, s7_bs;
  logic [CH_W-1:0] out_red_r, out_green_r, out_blue_r;

  always_comb begin
    case (s6_sext_r)
      SEXT_RED_YEL: begin s7_r = s6_vi_r; s7_g = s6_t_r;  s7_b = s6_p_r;  end
      SEXT_YEL_GRN: begin s7_r = s6_q_r;  s7_g = s6_vi_r; s7_b = s6_p_r;  end
      SEXT_GRN_CYN: begin s7_r = s6_p_r;  s7_g = s6_vi_r; s7_b = s6_t_r;  end
      SEXT_CYN_BLU: begin s7_r = s6_p_r;  s7_g = s6_q_r;  s7_b = s6_vi_r; end
      SEXT_BLU_MAG: begin s7_r = s6_t_r;  s7_g = s6_p_r;  s7_b = s6_vi_r; end
      default:      begin s7_r = s6_vi_r; s7_g = s6_p_r;  s7_b = s6_q_r;  end
    endcase
    // drop color: every channel carries the inverted value
    if (s6_grey_r) begin
      s7_r = s6_vi_r;
      s7_g = s6_vi_r;
      s7_b = s6_vi_r;
    end
    // x * 255 as (x << 8) - x
    s7_rs = {s7_r, 8'h00} - (QW+8)'(s7_r);
    s7_gs = {s7_g, 8'h00} - (QW+8)'(s7_g);
    s7_bs = {s7_b, 8'h00} - (QW+8)'(s7_b);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red_r   <= s7_rs[FRAC_BITS +: CH_W];
      out_green_r <= s7_gs[FRAC_BITS +: CH_W];
      out_blue_r  <= s7_bs[FRAC_BITS +: CH_W];
    end
  end

  assign out_red_out   = out_red_r;
  assign out_green_out = out_green_r;
  assign out_blue_out  = out_blue_r;

  // ---------------- assertions ----------------
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted word did not enter stage 1");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_rem_below_spread: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[2] && !s3_grey_r) |-> (s3_rem_r < s3_delta_r && s3_delta_r <= s3_mx_r))
    else $error("divider operands out of range");

  a_grey_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[NSTG-2] && s6_grey_r) |=>
      (out_red_out == out_green_out && out_green_out == out_blue_out))
    else $error("grey word left with unequal channels");

endmodule

`default_nettype wire
